/* rtl/ccc_pkg.sv */
// ============================================================================
// ccc_pkg - console cursor controller package
// Character codes, register indexes, draw kinds and field widths.
// ============================================================================
`default_nettype none

package ccc_pkg;

    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;
    localparam int PIX_W    = 14;
    localparam int GW_W     = 6;
    localparam int GH_W     = 7;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 8;
    localparam int OUT_DATA_W = 56;

    // control codes
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CH_HT = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

    localparam logic [POS_W:0] TAB_STEP = 9'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MARGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINAL_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERBOSE_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 3'd7;

    // register reset values
    localparam logic [POS_W-1:0] RST_LEFT_MARGIN   = 8'd0;
    localparam logic [POS_W-1:0] RST_RIGHT_MARGIN  = 8'd80;
    localparam logic [POS_W-1:0] RST_TOP_MARGIN    = 8'd0;
    localparam logic [POS_W-1:0] RST_BOTTOM_MARGIN = 8'd25;
    localparam logic             RST_TERMINAL_MODE = 1'b1;
    localparam logic             RST_VERBOSE_MODE  = 1'b0;
    localparam logic [GW_W-1:0]  RST_GLYPH_WIDTH   = 6'd8;
    localparam logic [GH_W-1:0]  RST_GLYPH_HEIGHT  = 7'd8;

    // draw kinds
    localparam logic [KIND_W-1:0] DRAW_NONE        = 2'd0;
    localparam logic [KIND_W-1:0] DRAW_OPAQUE      = 2'd1;
    localparam logic [KIND_W-1:0] DRAW_TRANSPARENT = 2'd2;

    typedef struct packed {
        logic              do_scroll;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [CHAR_W-1:0] glyph_code;
        logic [POS_W-1:0]  column_now;
        logic [POS_W-1:0]  row_now;
    } result_t;

endpackage

`default_nettype wire

/* rtl/console_cursor_controller.sv */
// An input transfer goes to the input register, its result then to the
// result register behind m_tvalid. One character per cycle unless the sink
// stalls; the cursor update and both pixel multiplies sit in the single
// stage between the two registers. Reset: rst_n (async, active low) clears
// the cursor to (0,0), CR flag, both valid bits; loads register defaults.
// ============================================================================
// console_cursor_controller - text console cursor control
// Tracks the text cursor per character and issues scroll and glyph draw
// commands at the pixel position of the updated cursor.
// ============================================================================
`default_nettype none

module console_cursor_controller
    import ccc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_W-1:0]    s_tdata,    // [7:0] char_code
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] do_scroll, [14:1] pixel_x, [28:15] pixel_y, [36:29] glyph_code,
    // [44:37] column_now, [52:45] row_now, [55:53] zero
    output logic [OUT_DATA_W-1:0]     m_tdata,
    output logic [KIND_W-1:0]         m_tuser,    // [1:0] draw_kind
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0] left_margin_reg;
    logic [POS_W-1:0] right_margin_reg;
    logic [POS_W-1:0] top_margin_reg;
    logic [POS_W-1:0] bottom_margin_reg;
    logic             terminal_mode_reg;
    logic             verbose_mode_reg;
    logic [GW_W-1:0]  glyph_width_reg;
    logic [GH_W-1:0]  glyph_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_margin_reg   <= RST_LEFT_MARGIN;
            right_margin_reg  <= RST_RIGHT_MARGIN;
            top_margin_reg    <= RST_TOP_MARGIN;
            bottom_margin_reg <= RST_BOTTOM_MARGIN;
            terminal_mode_reg <= RST_TERMINAL_MODE;
            verbose_mode_reg  <= RST_VERBOSE_MODE;
            glyph_width_reg   <= RST_GLYPH_WIDTH;
            glyph_height_reg  <= RST_GLYPH_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_MARGIN:   left_margin_reg   <= cfg_wdata;
                REG_RIGHT_MARGIN:  right_margin_reg  <= cfg_wdata;
                REG_TOP_MARGIN:    top_margin_reg    <= cfg_wdata;
                REG_BOTTOM_MARGIN: bottom_margin_reg <= cfg_wdata;
                REG_TERMINAL_MODE: terminal_mode_reg <= cfg_wdata[0];
                REG_VERBOSE_MODE:  verbose_mode_reg  <= cfg_wdata[0];
                REG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_wdata[GW_W-1:0];
                REG_GLYPH_HEIGHT:  glyph_height_reg  <= cfg_wdata[GH_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the result register stalls only when it holds a result
    // the sink has not taken; the input register advances whenever the
    // stage behind it moves.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              out_valid_reg;
    logic              out_stall;
    logic              proc_fire;
    logic              in_fire;

    assign out_stall = out_valid_reg && !m_tready;
    assign proc_fire = in_valid_reg && !out_stall;
    assign s_tready  = !in_valid_reg || !out_stall;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Cursor state
    // ------------------------------------------------------------------
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic             last_cr_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;
    logic             last_cr_next;
    logic             scroll_next;
    logic [KIND_W-1:0] kind_next;
    logic             is_print;

    // widened helpers for compares against margins
    logic [POS_W:0] row_inc;
    logic [POS_W:0] col_inc;
    logic [POS_W:0] col_tab;
    logic [POS_W:0] bottom_w;
    logic [POS_W:0] right_w;
    logic [POS_W:0] print_row;
    logic           wrap;

    assign row_inc  = {1'b0, row_reg} + 9'd1;
    assign col_inc  = {1'b0, col_reg} + 9'd1;
    assign col_tab  = {1'b0, col_reg} + TAB_STEP;
    assign bottom_w = {1'b0, bottom_margin_reg};
    assign right_w  = {1'b0, right_margin_reg};
    // wrap when column >= right_margin - 1, a zero margin always wraps
    assign wrap      = (col_inc >= right_w);
    assign print_row = wrap ? row_inc : {1'b0, row_reg};

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        last_cr_next = (char_reg == CH_CR);
        scroll_next  = 1'b0;
        kind_next    = DRAW_NONE;
        is_print     = 1'b0;
        case (char_reg)
            CH_FF:
            begin
                // home the cursor, keep the return flag
                col_next     = left_margin_reg;
                row_next     = top_margin_reg;
                last_cr_next = last_cr_reg;
            end
            CH_LF:
            begin
                // at or below the last row: scroll, column kept
                if (bottom_margin_reg == '0 || row_inc >= bottom_w)
                begin
                    scroll_next = 1'b1;
                    row_next    = (bottom_margin_reg == '0) ? '0
                                  : bottom_margin_reg - 8'd1;
                end
                else
                begin
                    row_next = row_inc[POS_W-1:0];
                    if (last_cr_reg || terminal_mode_reg || verbose_mode_reg)
                    begin
                        col_next = left_margin_reg;
                    end
                end
            end
            CH_HT:
            begin
                col_next = col_tab[POS_W] ? '1 : col_tab[POS_W-1:0];
            end
            CH_CR:
            begin
                col_next = left_margin_reg;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - 8'd1;
                end
            end
            default:
            begin
                is_print = 1'b1;
                col_next = wrap ? left_margin_reg : col_inc[POS_W-1:0];
                if (print_row >= bottom_w)
                begin
                    scroll_next = 1'b1;
                    row_next    = bottom_margin_reg;
                end
                else
                begin
                    row_next = print_row[POS_W-1:0];
                end
                kind_next = terminal_mode_reg ? DRAW_OPAQUE : DRAW_TRANSPARENT;
            end
        endcase
    end

    // pixel position of the new cursor, low 14 bits kept
    logic [GW_W+POS_W-1:0] px_prod;
    logic [GH_W+POS_W-1:0] py_prod;

    assign px_prod = {{POS_W{1'b0}}, glyph_width_reg} * {{GW_W{1'b0}}, col_next};
    assign py_prod = {{POS_W{1'b0}}, glyph_height_reg} * {{GH_W{1'b0}}, row_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            last_cr_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            last_cr_reg <= last_cr_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    result_t          res_reg;
    result_t          res_next;
    logic [KIND_W-1:0] kind_reg;

    always_comb
    begin
        res_next.do_scroll  = scroll_next;
        res_next.pixel_x    = is_print ? px_prod[PIX_W-1:0] : '0;
        res_next.pixel_y    = is_print ? py_prod[PIX_W-1:0] : '0;
        res_next.glyph_code = is_print ? char_reg : '0;
        res_next.column_now = col_next;
        res_next.row_now    = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            res_reg  <= res_next;
            kind_reg <= kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b000, res_reg.row_now, res_reg.column_now,
                       res_reg.glyph_code, res_reg.pixel_y, res_reg.pixel_x,
                       res_reg.do_scroll};

endmodule

`default_nettype wire

/* rtl/ccc_checker.sv */
// ============================================================================
// ccc_checker - port checks for the console cursor controller
// Watches the result stream and flags illegal or inconsistent transfers.
// ============================================================================
`default_nettype none

module ccc_checker
    import ccc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]     m_tuser
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // draw kind three never appears
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == DRAW_NONE || m_tuser == DRAW_OPAQUE
                      || m_tuser == DRAW_TRANSPARENT))
        else $error("illegal draw kind");

    // control codes carry no pixel position or glyph
    a_nodraw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == DRAW_NONE |-> m_tdata[36:1] == '0)
        else $error("draw fields set without a draw");

    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[55:53] == 3'b000)
        else $error("pad bits set");

endmodule

bind console_cursor_controller ccc_checker u_ccc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/console_cursor_controller_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// console_cursor_controller_checker - cursor tracking scoreboard
// Mirrors the register writes, tracks the text cursor for every accepted
// character and compares each result transfer field by field with the
// oldest predicted cursor update.
// ============================================================================

module console_cursor_controller_checker
    import ccc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0]     m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int X_LSB   = 1;
    localparam int Y_LSB   = X_LSB + PIX_W;
    localparam int G_LSB   = Y_LSB + PIX_W;
    localparam int C_LSB   = G_LSB + CHAR_W;
    localparam int R_LSB   = C_LSB + POS_W;
    localparam int PAD_LSB = R_LSB + POS_W;

    typedef struct packed {
        logic              scroll;
        logic [KIND_W-1:0] kind;
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  py;
        logic [CHAR_W-1:0] glyph;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
    } cursor_update_t;

    cursor_update_t    expected_updates[$];

    // register mirror
    logic [POS_W-1:0]  left_m, right_m, top_m, bottom_m;
    logic              term_m, verb_m;
    logic [GW_W-1:0]   cell_w;
    logic [GH_W-1:0]   cell_h;

    // cursor state
    logic [POS_W-1:0]  cur_col, cur_row;
    logic              after_cr;

    function automatic cursor_update_t track_char(input logic [CHAR_W-1:0] ch);
        cursor_update_t u;
        int col;
        int row;
        int last_row;
        int prod_x;
        int prod_y;
        u = '0;
        col = cur_col;
        row = cur_row;
        last_row = int'(bottom_m) - 1;
        if (ch == CH_FF)
        begin
            // home to the top-left margin corner; the CR flag is kept
            row = top_m;
            col = left_m;
        end
        else
        begin
            case (ch)
                CH_LF:
                begin
                    if (row >= last_row)
                    begin
                        // a zero bottom margin makes every line feed scroll
                        u.scroll = 1'b1;
                        row = (last_row < 0) ? 0 : last_row;
                    end
                    else
                    begin
                        row++;
                        if (after_cr || term_m || verb_m)
                            col = left_m;
                    end
                end
                CH_HT:
                begin
                    col += int'(TAB_STEP);
                    if (col > 255)
                        col = 255;
                end
                CH_CR:
                    col = left_m;
                CH_BS:
                    if (col > 0)
                        col--;
                default:
                begin
                    if (col >= int'(right_m) - 1)
                    begin
                        col = left_m;
                        row++;
                    end
                    else
                        col++;
                    if (row >= int'(bottom_m))
                    begin
                        u.scroll = 1'b1;
                        row = bottom_m;
                    end
                    u.kind = term_m ? DRAW_OPAQUE : DRAW_TRANSPARENT;
                    // keep the low bits of the pixel products only
                    prod_x = int'(cell_w) * col;
                    prod_y = int'(cell_h) * row;
                    u.px = prod_x[PIX_W-1:0];
                    u.py = prod_y[PIX_W-1:0];
                    u.glyph = ch;
                end
            endcase
            after_cr = (ch == CH_CR);
        end
        cur_col = col[POS_W-1:0];
        cur_row = row[POS_W-1:0];
        u.col = cur_col;
        u.row = cur_row;
        return u;
    endfunction

    task automatic note_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch on %s: expected %0d, got %0d",
                         $realtime, label, want, got);
        end
    endtask

    task automatic check_result();
        cursor_update_t want;
        if (expected_updates.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t result transfer with no character pending: tdata %h",
                         $realtime, m_tdata);
        end
        else
        begin
            want = expected_updates.pop_front();
            note_field("do_scroll", want.scroll, m_tdata[0]);
            note_field("draw_kind", want.kind, m_tuser);
            note_field("pixel_x", want.px, m_tdata[X_LSB +: PIX_W]);
            note_field("pixel_y", want.py, m_tdata[Y_LSB +: PIX_W]);
            note_field("glyph_code", want.glyph, m_tdata[G_LSB +: CHAR_W]);
            note_field("column_now", want.col, m_tdata[C_LSB +: POS_W]);
            note_field("row_now", want.row, m_tdata[R_LSB +: POS_W]);
            note_field("tdata padding", '0, m_tdata[OUT_DATA_W-1:PAD_LSB]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_m   = RST_LEFT_MARGIN;
            right_m  = RST_RIGHT_MARGIN;
            top_m    = RST_TOP_MARGIN;
            bottom_m = RST_BOTTOM_MARGIN;
            term_m   = RST_TERMINAL_MODE;
            verb_m   = RST_VERBOSE_MODE;
            cell_w   = RST_GLYPH_WIDTH;
            cell_h   = RST_GLYPH_HEIGHT;
            cur_col  = '0;
            cur_row  = '0;
            after_cr = 1'b0;
            expected_updates.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEFT_MARGIN:   left_m   = cfg_wdata;
                    REG_RIGHT_MARGIN:  right_m  = cfg_wdata;
                    REG_TOP_MARGIN:    top_m    = cfg_wdata;
                    REG_BOTTOM_MARGIN: bottom_m = cfg_wdata;
                    REG_TERMINAL_MODE: term_m   = cfg_wdata[0];
                    REG_VERBOSE_MODE:  verb_m   = cfg_wdata[0];
                    REG_GLYPH_WIDTH:   cell_w   = cfg_wdata[GW_W-1:0];
                    REG_GLYPH_HEIGHT:  cell_h   = cfg_wdata[GH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_updates.push_back(track_char(s_tdata));
            if (m_tvalid && m_tready)
                check_result();
            outstanding = expected_updates.size();
        end
    end

endmodule

/* sim/console_cursor_controller_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// console_cursor_controller_tb - cursor controller regression
// Streams directed and random character codes through the block under
// several register settings, with random gaps on the input side and random
// back-pressure on the result side; a separate checker predicts and compares.
// ============================================================================

module console_cursor_controller_tb;

    import ccc_pkg::*;

    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int CHARS_PER_PHASE = 104;
    // leave headroom for stray transfers
    localparam int SETTLE_CYCLES   = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata = '0;       // [7:0] char_code
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] do_scroll, [14:1] pixel_x, [28:15] pixel_y, [36:29] glyph_code,
    // [44:37] column_now, [52:45] row_now, [55:53] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;            // [1:0] draw_kind
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int stall_left = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    console_cursor_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    console_cursor_controller_checker cursor_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Abort a hung run; the limit covers every character waiting out the
    // longest gap and the longest stall back to back, many times over.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("console_cursor_controller regression: fail");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: stall at random unless the phase asks for steady flow.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (rx_steady || $urandom_range(0, 2) != 0)
            m_tready <= 1'b1;
        else
        begin
            stall_left <= idle_len();
            m_tready <= 1'b0;
        end
    end

    // Offer one character and hold it until the transfer happens. Valid stays
    // high on return so back-to-back characters need no second assignment.
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid and hold off until every predicted result has arrived.
    // Sample at the falling edge so the checker's count has settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Write every register; mode and glyph values go in as raw bytes so the
    // unused upper bits get exercised too.
    task automatic load_regs(input logic [CFG_W-1:0] lm, rm, tm, bm,
                             input logic [CFG_W-1:0] tmode, vmode, gw, gh);
        write_reg(REG_LEFT_MARGIN, lm);
        write_reg(REG_RIGHT_MARGIN, rm);
        write_reg(REG_TOP_MARGIN, tm);
        write_reg(REG_BOTTOM_MARGIN, bm);
        write_reg(REG_TERMINAL_MODE, tmode);
        write_reg(REG_VERBOSE_MODE, vmode);
        write_reg(REG_GLYPH_WIDTH, gw);
        write_reg(REG_GLYPH_HEIGHT, gh);
        cfg_we <= 1'b0;
    endtask

    // Margin: mostly a realistic window, sometimes an extreme or any byte.
    function automatic logic [CFG_W-1:0] margin_value(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return CFG_W'($urandom_range(0, 255));
        return CFG_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [CFG_W-1:0] cell_value();
        if ($urandom_range(0, 4) == 0)
            return CFG_W'($urandom_range(0, 255));
        return CFG_W'($urandom_range(4, 16));
    endfunction

    // Character mix: plenty of control codes so the cursor keeps moving in
    // every direction, the rest any byte at all.
    function automatic logic [CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CH_BS;
        if (r < 16)
            return CH_HT;
        if (r < 26)
            return CH_LF;
        if (r < 30)
            return CH_FF;
        if (r < 38)
            return CH_CR;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int sent;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: line feed plain and after return, tab, backspace
        // down to the left edge, form feed, and the byte extremes.
        send_char(8'h41);
        send_char(CH_LF);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_HT);
        send_char(CH_BS);
        send_char(CH_FF);
        send_char(CH_BS);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        wait_drained();

        // Zero right and bottom margins, zero glyph size, transparent mode:
        // tab saturates at the last column, every printable wraps and every
        // line feed scrolls.
        load_regs(8'd250, 8'd0, 8'd255, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_char(CH_FF);
        send_char(CH_HT);
        send_char(CH_HT);
        send_char(8'h55);
        send_char(CH_LF);
        send_char(8'hAA);
        wait_drained();

        // Widest cells near the bottom row so the pixel products overflow.
        load_regs(8'd3, 8'd255, 8'd254, 8'd255, 8'hFE, 8'h01, 8'hFF, 8'hFF);
        send_char(CH_FF);
        send_char(8'h21);
        send_char(CH_LF);
        send_char(CH_BS);
        send_char(CH_HT);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_regs(margin_value(0, 10), margin_value(12, 80),
                      margin_value(0, 5), margin_value(4, 30),
                      CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                      cell_value(), cell_value());
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < CHARS_PER_PHASE)
            begin
                // carriage return and line feed pairs get their own share
                if ($urandom_range(0, 9) == 0)
                begin
                    send_char(CH_CR);
                    send_char(CH_LF);
                    sent += 2;
                end
                else
                begin
                    send_char(random_char());
                    sent++;
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("console_cursor_controller regression: pass");
        else
            $display("console_cursor_controller regression: fail");
        $finish;
    end

endmodule
